### hdl/rpac_pkg.sv
// rpac_pkg: shared constants, types and request structs for the read pair agreement counter
// no dependencies; used by every module under hdl
package rpac_pkg;

    localparam int MaxReads   = 64;
    localparam int ReadW      = $clog2(MaxReads);
    localparam int FillW      = ReadW + 1;
    localparam int BaseW      = 8;
    localparam int CountW     = 16;
    localparam int PairAddrW  = 2 * ReadW;
    localparam int CfgW       = 7;

    localparam logic [1:0]       FUNC_ENTRY = 2'd0;
    localparam logic [1:0]       FUNC_QUERY = 2'd1;
    localparam logic [1:0]       FUNC_CLEAR = 2'd2;
    localparam logic [BaseW-1:0] NO_BASE    = 8'h20;
    localparam logic [CfgW-1:0]  READS_RST  = 7'd64;
    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P1_RD,
        ST_P1_CMP,
        ST_P1_END,
        ST_P2_RD,
        ST_P2_CHK,
        ST_P2_UPD,
        ST_Q_RD,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [ReadW-1:0] wr_addr;
        logic [ReadW-1:0] wr_read;
        logic [BaseW-1:0] wr_base;
        logic             aux_wr_en;
        logic [ReadW-1:0] aux_addr;
        logic [FillW-1:0] aux_cnt;
        logic             aux_dup;
        logic [ReadW-1:0] rd_a;
        logic [ReadW-1:0] rd_b;
    } col_req_t;

    typedef struct packed {
        logic [ReadW-1:0] read_a;
        logic [BaseW-1:0] base_a;
        logic [FillW-1:0] cnt_a;
        logic             dup_a;
        logic [ReadW-1:0] read_b;
        logic [BaseW-1:0] base_b;
        logic [FillW-1:0] cnt_b;
        logic             dup_b;
    } col_rsp_t;

    typedef struct packed {
        logic [PairAddrW-1:0] rd_addr;
        logic                 wr_en;
        logic [PairAddrW-1:0] wr_addr;
        logic [CountW-1:0]    wr_sim;
        logic [CountW-1:0]    wr_dif;
    } pair_req_t;

    typedef struct packed {
        logic [CountW-1:0] sim;
        logic [CountW-1:0] dif;
    } pair_rsp_t;

endpackage

### hdl/rpac_col_store.sv
// rpac_col_store: column entry memory and per-entry histogram/duplicate memory
// two registered read ports each; depends on rpac_pkg
module rpac_col_store (
    input  logic              clk,
    input  rpac_pkg::col_req_t req,
    output rpac_pkg::col_rsp_t rsp
);

    logic [rpac_pkg::ReadW-1:0] col_read_mem [rpac_pkg::MaxReads];
    logic [rpac_pkg::BaseW-1:0] col_base_mem [rpac_pkg::MaxReads];
    logic [rpac_pkg::FillW-1:0] aux_cnt_mem  [rpac_pkg::MaxReads];
    logic                       aux_dup_mem  [rpac_pkg::MaxReads];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            col_read_mem[req.wr_addr] <= req.wr_read;
            col_base_mem[req.wr_addr] <= req.wr_base;
        end
        if (req.aux_wr_en)
        begin
            aux_cnt_mem[req.aux_addr] <= req.aux_cnt;
            aux_dup_mem[req.aux_addr] <= req.aux_dup;
        end
        rsp.read_a <= col_read_mem[req.rd_a];
        rsp.base_a <= col_base_mem[req.rd_a];
        rsp.cnt_a  <= aux_cnt_mem[req.rd_a];
        rsp.dup_a  <= aux_dup_mem[req.rd_a];
        rsp.read_b <= col_read_mem[req.rd_b];
        rsp.base_b <= col_base_mem[req.rd_b];
        rsp.cnt_b  <= aux_cnt_mem[req.rd_b];
        rsp.dup_b  <= aux_dup_mem[req.rd_b];
    end

endmodule

### hdl/rpac_pair_store.sv
// rpac_pair_store: pair counter memory, one write and one registered read port
// depends on rpac_pkg
module rpac_pair_store (
    input  logic               clk,
    input  rpac_pkg::pair_req_t req,
    output rpac_pkg::pair_rsp_t rsp
);

    logic [2*rpac_pkg::CountW-1:0] pair_mem [2**rpac_pkg::PairAddrW];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            pair_mem[req.wr_addr] <= {req.wr_sim, req.wr_dif};
        end
        {rsp.sim, rsp.dif} <= pair_mem[req.rd_addr];
    end

endmodule

### hdl/rpac_ctrl.sv
// rpac_ctrl: sequencer with the shared compare/saturating-add unit
// drives rpac_col_store and rpac_pair_store; depends on rpac_pkg
module rpac_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rpac_pkg::CfgW-1:0]   reads_in_use,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [rpac_pkg::ReadW-1:0]  read_index,
    input  logic [rpac_pkg::BaseW-1:0]  base,
    input  logic                        last_entry,
    input  logic [rpac_pkg::ReadW-1:0]  other_read,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rpac_pkg::CountW-1:0] similar_count,
    output logic [rpac_pkg::CountW-1:0] different_count,
    output rpac_pkg::col_req_t          col_req,
    input  rpac_pkg::col_rsp_t          col_rsp,
    output rpac_pkg::pair_req_t         pair_req,
    input  rpac_pkg::pair_rsp_t         pair_rsp
);

    localparam int RW = rpac_pkg::ReadW;
    localparam int FW = rpac_pkg::FillW;
    localparam int AW = rpac_pkg::PairAddrW;
    localparam int CW = rpac_pkg::CountW;
    localparam int BW = rpac_pkg::BaseW;

    rpac_pkg::state_t state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] i_reg, i_next, j_reg, j_next;
    logic [FW-1:0] cnt_reg, cnt_next;
    logic          first_reg, first_next, dup_reg, dup_next;
    logic [FW-1:0] most_c_reg, most_c_next, sec_c_reg, sec_c_next;
    logic [BW-1:0] most_b_reg, most_b_next, sec_b_reg, sec_b_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic          same_reg, same_next, three_reg, three_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_sim_reg, out_sim_next, out_dif_reg, out_dif_next;

    logic          accept;
    logic          same_base, same_read, earlier, elig;
    logic [AW-1:0] chk_addr;
    logic [CW:0]   sum;
    logic [CW-1:0] sat;
    logic [CW-1:0] inc;

    assign accept          = in_valid && in_ready;
    assign in_ready        = (state_reg == rpac_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign similar_count   = out_sim_reg;
    assign different_count = out_dif_reg;

    assign same_base = (col_rsp.base_a == col_rsp.base_b);
    assign same_read = (col_rsp.read_a == col_rsp.read_b);
    assign earlier   = (j_reg < i_reg);
    assign elig      = !col_rsp.dup_a && !col_rsp.dup_b
                       && (col_rsp.cnt_a >= sec_c_reg) && (col_rsp.cnt_b >= sec_c_reg);
    assign chk_addr  = (col_rsp.read_a < col_rsp.read_b)
                       ? {col_rsp.read_a, col_rsp.read_b} : {col_rsp.read_b, col_rsp.read_a};

    assign inc = three_reg ? CW'(3) : CW'(1);
    assign sum = same_reg ? ({1'b0, pair_rsp.sim} + {1'b0, inc})
                          : ({1'b0, pair_rsp.dif} + {1'b0, inc});
    assign sat = sum[CW] ? rpac_pkg::COUNT_MAX : sum[CW-1:0];

    always_comb
    begin
        col_req.wr_en     = 1'b0;
        col_req.wr_addr   = fill_reg[RW-1:0];
        col_req.wr_read   = read_index;
        col_req.wr_base   = base;
        col_req.aux_wr_en = (state_reg == rpac_pkg::ST_P1_END);
        col_req.aux_addr  = i_reg[RW-1:0];
        col_req.aux_cnt   = cnt_reg;
        col_req.aux_dup   = dup_reg;
        col_req.rd_a      = i_reg[RW-1:0];
        col_req.rd_b      = j_reg[RW-1:0];
        if (accept && func == rpac_pkg::FUNC_ENTRY
            && ({1'b0, read_index} < FW'(reads_in_use))
            && (fill_reg < FW'(rpac_pkg::MaxReads)))
        begin
            col_req.wr_en = 1'b1;
        end
        pair_req.rd_addr = (state_reg == rpac_pkg::ST_P2_CHK) ? chk_addr : paddr_reg;
        pair_req.wr_en   = 1'b0;
        pair_req.wr_addr = paddr_reg;
        pair_req.wr_sim  = pair_rsp.sim;
        pair_req.wr_dif  = pair_rsp.dif;
        if (state_reg == rpac_pkg::ST_CLEAR)
        begin
            pair_req.wr_en   = 1'b1;
            pair_req.wr_addr = clr_reg;
            pair_req.wr_sim  = '0;
            pair_req.wr_dif  = '0;
        end
        else if (state_reg == rpac_pkg::ST_P2_UPD)
        begin
            pair_req.wr_en = 1'b1;
            if (same_reg)
            begin
                pair_req.wr_sim = sat;
            end
            else
            begin
                pair_req.wr_dif = sat;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        dup_next       = dup_reg;
        most_c_next    = most_c_reg;
        most_b_next    = most_b_reg;
        sec_c_next     = sec_c_reg;
        sec_b_next     = sec_b_reg;
        paddr_next     = paddr_reg;
        same_next      = same_reg;
        three_next     = three_reg;
        clr_next       = clr_reg;
        out_sim_next   = out_sim_reg;
        out_dif_next   = out_dif_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            rpac_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = rpac_pkg::ST_IDLE;
                end
            end
            rpac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        rpac_pkg::FUNC_ENTRY:
                        begin
                            fill_next = fill_reg + FW'(col_req.wr_en);
                            if (last_entry)
                            begin
                                i_next      = '0;
                                j_next      = '0;
                                cnt_next    = '0;
                                first_next  = 1'b1;
                                dup_next    = 1'b0;
                                most_c_next = '0;
                                sec_c_next  = '0;
                                most_b_next = rpac_pkg::NO_BASE;
                                sec_b_next  = rpac_pkg::NO_BASE;
                                if (fill_next == '0)
                                begin
                                    state_next = rpac_pkg::ST_IDLE;
                                end
                                else
                                begin
                                    state_next = rpac_pkg::ST_P1_RD;
                                end
                            end
                        end
                        rpac_pkg::FUNC_QUERY:
                        begin
                            paddr_next = (read_index < other_read)
                                         ? {read_index, other_read} : {other_read, read_index};
                            state_next = rpac_pkg::ST_Q_RD;
                        end
                        rpac_pkg::FUNC_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = rpac_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = rpac_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rpac_pkg::ST_P1_RD:
            begin
                state_next = rpac_pkg::ST_P1_CMP;
            end
            rpac_pkg::ST_P1_CMP:
            begin
                cnt_next = cnt_reg + FW'(same_base);
                if (earlier && same_base)
                begin
                    first_next = 1'b0;
                end
                if (earlier && same_read)
                begin
                    dup_next = 1'b1;
                end
                j_next = j_reg + FW'(1);
                if (j_next == fill_reg)
                begin
                    state_next = rpac_pkg::ST_P1_END;
                end
                else
                begin
                    state_next = rpac_pkg::ST_P1_RD;
                end
            end
            rpac_pkg::ST_P1_END:
            begin
                if (first_reg)
                begin
                    if (cnt_reg > most_c_reg)
                    begin
                        sec_c_next  = most_c_reg;
                        sec_b_next  = most_b_reg;
                        most_c_next = cnt_reg;
                        most_b_next = col_rsp.base_a;
                    end
                    else if (cnt_reg > sec_c_reg)
                    begin
                        sec_c_next = cnt_reg;
                        sec_b_next = col_rsp.base_a;
                    end
                end
                cnt_next   = '0;
                first_next = 1'b1;
                dup_next   = 1'b0;
                j_next     = '0;
                i_next     = i_reg + FW'(1);
                if (i_next == fill_reg)
                begin
                    if (fill_reg < FW'(2))
                    begin
                        fill_next  = '0;
                        state_next = rpac_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = FW'(1);
                        state_next = rpac_pkg::ST_P2_RD;
                    end
                end
                else
                begin
                    state_next = rpac_pkg::ST_P1_RD;
                end
            end
            rpac_pkg::ST_P2_RD:
            begin
                state_next = rpac_pkg::ST_P2_CHK;
            end
            rpac_pkg::ST_P2_CHK, rpac_pkg::ST_P2_UPD:
            begin
                if (state_reg == rpac_pkg::ST_P2_CHK && elig)
                begin
                    paddr_next = chk_addr;
                    same_next  = same_base;
                    three_next = same_base && (col_rsp.base_a == sec_b_reg);
                    state_next = rpac_pkg::ST_P2_UPD;
                end
                else if (j_reg + FW'(1) < fill_reg)
                begin
                    j_next     = j_reg + FW'(1);
                    state_next = rpac_pkg::ST_P2_RD;
                end
                else if (i_reg + FW'(2) < fill_reg)
                begin
                    i_next     = i_reg + FW'(1);
                    j_next     = i_reg + FW'(2);
                    state_next = rpac_pkg::ST_P2_RD;
                end
                else
                begin
                    fill_next  = '0;
                    state_next = rpac_pkg::ST_IDLE;
                end
            end
            rpac_pkg::ST_Q_RD:
            begin
                state_next = rpac_pkg::ST_Q_OUT;
            end
            rpac_pkg::ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sim_next   = pair_rsp.sim;
                    out_dif_next   = pair_rsp.dif;
                    state_next     = rpac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpac_pkg::ST_CLEAR;
            fill_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        cnt_reg     <= cnt_next;
        first_reg   <= first_next;
        dup_reg     <= dup_next;
        most_c_reg  <= most_c_next;
        most_b_reg  <= most_b_next;
        sec_c_reg   <= sec_c_next;
        sec_b_reg   <= sec_b_next;
        paddr_reg   <= paddr_next;
        same_reg    <= same_next;
        three_reg   <= three_next;
        out_sim_reg <= out_sim_next;
        out_dif_reg <= out_dif_next;
    end

endmodule

### hdl/read_pair_agreement_counter_top.sv
// read_pair_agreement_counter_top: top level, config register and stream port packing
// instantiates rpac_ctrl, rpac_col_store, rpac_pair_store; depends on rpac_pkg
//
// channel | direction | contents
// s_axis  | in        | tdata: func, read_index, base, other_read; tlast: last_entry
// m_axis  | out       | tdata: similar_count, different_count
// cfg     | in        | cfg_wen, cfg_wdata: reads_in_use
//
// the closing entry starts a histogram pass of base compares over every pair of
// stored entries, then a pass over the read pairs that updates eligible pair counters
// through the shared compare unit and the single pair counter port
// a query reads one pair counter; a clear sweeps the 4096 counters
// after reset the same clearing pass runs before the first transaction
// a query result waits in an output register while m_axis_tready is low
module read_pair_agreement_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // func, read_index, base, other_read, zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // similar_count, different_count
);

    logic [rpac_pkg::CfgW-1:0] reads_in_use_reg;
    rpac_pkg::col_req_t        col_req;
    rpac_pkg::col_rsp_t        col_rsp;
    rpac_pkg::pair_req_t       pair_req;
    rpac_pkg::pair_rsp_t       pair_rsp;
    logic [rpac_pkg::CountW-1:0] similar_count;
    logic [rpac_pkg::CountW-1:0] different_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_in_use_reg <= rpac_pkg::READS_RST;
        end
        else if (cfg_wen)
        begin
            reads_in_use_reg <= cfg_wdata;
        end
    end

    assign m_axis_tdata = {different_count, similar_count};

    rpac_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .reads_in_use    (reads_in_use_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .func            (s_axis_tdata[1:0]),
        .read_index      (s_axis_tdata[7:2]),
        .base            (s_axis_tdata[15:8]),
        .last_entry      (s_axis_tlast),
        .other_read      (s_axis_tdata[21:16]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .similar_count   (similar_count),
        .different_count (different_count),
        .col_req         (col_req),
        .col_rsp         (col_rsp),
        .pair_req        (pair_req),
        .pair_rsp        (pair_rsp)
    );

    rpac_col_store u_col_store (
        .clk (clk),
        .req (col_req),
        .rsp (col_rsp)
    );

    rpac_pair_store u_pair_store (
        .clk (clk),
        .req (pair_req),
        .rsp (pair_rsp)
    );

endmodule
